// ===== hdl/lavm_pkg.sv =====
package lavm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int DIFF_W        = 33;
    localparam int MUL_W         = 33;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int SQ_W          = 64;
    localparam int ROWS          = 12;
    localparam int ROW_W         = $clog2(ROWS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_UP_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_Z = 2'd2;

    localparam logic [1:0] MAT_VIEW  = 2'd0;
    localparam logic [1:0] MAT_BILL  = 2'd1;
    localparam logic [1:0] MAT_YBILL = 2'd2;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] eye_x;
        logic signed [DATA_W-1:0] eye_y;
        logic signed [DATA_W-1:0] eye_z;
        logic signed [DIFF_W-1:0] d_x;
        logic signed [DIFF_W-1:0] d_y;
        logic signed [DIFF_W-1:0] d_z;
        logic                     degen;
    } item_t;

    typedef struct packed {
        logic [2:0][DATA_W-1:0] ax;
        logic [2:0][DATA_W-1:0] ay;
        logic [2:0][DATA_W-1:0] az;
        logic [2:0][DATA_W-1:0] tr;
        logic [2:0][DATA_W-1:0] un;
        logic [2:0][DATA_W-1:0] zb;
        logic                   degen;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_NMAG, ST_NSHIFT, ST_MUL, ST_ACC, ST_POST,
        ST_SQRT, ST_DINIT, ST_DIV, ST_NEXT, ST_HAND
    } state_t;

    typedef enum logic [2:0] {
        PG_AZ, PG_UX, PG_AX, PG_AY, PG_T, PG_UN, PG_ZB
    } prog_t;

    function automatic logic [1:0] nxt3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-DATA_W:0] hi;
        hi = v[PROD_W-1:DATA_W-1];
        if (hi == '0 || hi == '1) begin
            return v[DATA_W-1:0];
        end
        return v[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

// ===== hdl/look_at_view_matrix_core.sv =====
// Left-handed look-at camera core in signed fixed point (FRAC_BITS fraction bits, Q16.16
// by default). Each input transaction (eye, target) yields twelve result rows: view matrix,
// full billboard and Y-axis billboard, with the up vector taken from configuration
// registers 0..2 (these are to be written by the user only while the core is idle; the
// core itself does not enforce this). A two-entry input queue holds items while the
// compute engine works; the engine runs three normalizations and the cross/dot products
// through one shared 33x33 multiplier, a bit-serial square root and a bit-serial divider,
// and skips the square root and division when a vector to normalize is zero. Row emission
// of one transaction overlaps the computation of the next.
module look_at_view_matrix_core #(
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_eye_x,
    input  logic signed [31:0]          s_eye_y,
    input  logic signed [31:0]          s_eye_z,
    input  logic signed [31:0]          s_target_x,
    input  logic signed [31:0]          s_target_y,
    input  logic signed [31:0]          s_target_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_matrix_id,
    output logic [1:0]                  m_row_index,
    output logic signed [31:0]          m_col0,
    output logic signed [31:0]          m_col1,
    output logic signed [31:0]          m_col2,
    output logic signed [31:0]          m_col3,
    output logic                        m_degenerate,
    output logic                        m_last_row,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [31:0]                 cfg_data
);

    localparam logic [31:0] ONE_D = 32'(1) << FRAC_BITS;

    logic signed [31:0]     up_x_reg, up_y_reg, up_z_reg;
    logic                   q_valid, q_ready;
    lavm_pkg::item_t        q_item;
    logic                   res_valid, res_ready;
    lavm_pkg::res_t         res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_x_reg <= '0;
            up_y_reg <= ONE_D;
            up_z_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lavm_pkg::CFG_UP_X: up_x_reg <= cfg_data;
                lavm_pkg::CFG_UP_Y: up_y_reg <= cfg_data;
                lavm_pkg::CFG_UP_Z: up_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    lavm_front u_front (
        .clk      (aclk),
        .rstn     (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .eye_x    (s_eye_x),
        .eye_y    (s_eye_y),
        .eye_z    (s_eye_z),
        .target_x (s_target_x),
        .target_y (s_target_y),
        .target_z (s_target_z),
        .up_x     (up_x_reg),
        .up_y     (up_y_reg),
        .up_z     (up_z_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    lavm_engine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .clk       (aclk),
        .rstn      (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .up_x      (up_x_reg),
        .up_y      (up_y_reg),
        .up_z      (up_z_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    lavm_emit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_emit (
        .clk          (aclk),
        .rstn         (aresetn),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_matrix_id  (m_matrix_id),
        .m_row_index  (m_row_index),
        .m_col0       (m_col0),
        .m_col1       (m_col1),
        .m_col2       (m_col2),
        .m_col3       (m_col3),
        .m_degenerate (m_degenerate),
        .m_last_row   (m_last_row)
    );

endmodule

// ===== hdl/lavm_front.sv =====
module lavm_front (
    input  logic                        clk,
    input  logic                        rstn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          eye_x,
    input  logic signed [31:0]          eye_y,
    input  logic signed [31:0]          eye_z,
    input  logic signed [31:0]          target_x,
    input  logic signed [31:0]          target_y,
    input  logic signed [31:0]          target_z,
    input  logic signed [31:0]          up_x,
    input  logic signed [31:0]          up_y,
    input  logic signed [31:0]          up_z,
    output logic                        q_valid,
    input  logic                        q_ready,
    output lavm_pkg::item_t             q_item
);

    lavm_pkg::item_t                    queue_reg [lavm_pkg::QUEUE_DEPTH];
    logic [lavm_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [lavm_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [lavm_pkg::QCNT_W-1:0]        count_reg;
    lavm_pkg::item_t                    new_item;
    logic                               push;
    logic                               pop;

    always_comb begin
        new_item.eye_x = eye_x;
        new_item.eye_y = eye_y;
        new_item.eye_z = eye_z;
        new_item.d_x   = lavm_pkg::DIFF_W'(target_x) - lavm_pkg::DIFF_W'(eye_x);
        new_item.d_y   = lavm_pkg::DIFF_W'(target_y) - lavm_pkg::DIFF_W'(eye_y);
        new_item.d_z   = lavm_pkg::DIFF_W'(target_z) - lavm_pkg::DIFF_W'(eye_z);
        new_item.degen = (new_item.d_x == '0 && new_item.d_y == '0 && new_item.d_z == '0)
                      || (up_x == '0 && up_y == '0 && up_z == '0);
    end

    assign s_ready = count_reg != lavm_pkg::QCNT_W'(lavm_pkg::QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = queue_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge clk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == lavm_pkg::QPTR_W'(lavm_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == lavm_pkg::QPTR_W'(lavm_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/lavm_engine.sv =====
module lavm_engine #(
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rstn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  lavm_pkg::item_t             q_item,
    input  logic signed [31:0]          up_x,
    input  logic signed [31:0]          up_y,
    input  logic signed [31:0]          up_z,
    output logic                        res_valid,
    input  logic                        res_ready,
    output lavm_pkg::res_t              res
);

    localparam int UW     = FRAC_BITS + 2;
    localparam int NV_W   = FRAC_BITS + 34;
    localparam int DC_W   = $clog2(FRAC_BITS + 1);
    localparam int MW     = lavm_pkg::MUL_W;
    localparam int PW     = lavm_pkg::PROD_W;
    localparam int SW     = lavm_pkg::SQ_W;
    localparam int DW     = lavm_pkg::DATA_W;

    localparam logic [NV_W-1:0] TH_HI4 = NV_W'(1) << 34;
    localparam logic [NV_W-1:0] TH_HI  = NV_W'(1) << 30;
    localparam logic [NV_W-1:0] TH_LO4 = NV_W'(1) << 25;
    localparam logic [NV_W-1:0] TH_LO  = NV_W'(1) << 29;
    localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic signed [PW-1:0] ONE_M1 = (PW'(1) << FRAC_BITS) - PW'(1);
    localparam logic [SW-1:0] BIT_INIT = SW'(1) << (SW - 2);

    lavm_pkg::state_t state_reg, state_next;
    lavm_pkg::prog_t  pc_reg, pc_next;
    logic [1:0]       ci_reg, ci_next;
    logic [1:0]       ti_reg, ti_next;
    logic             degen_reg, degen_next;

    logic signed [DW-1:0]   eye_reg [3], eye_next [3];
    logic signed [NV_W-1:0] nv_reg [3], nv_next [3];
    logic [NV_W-1:0]        m_reg [3], m_next [3];
    logic signed [UW-1:0]   az_reg [3], az_next [3];
    logic signed [UW-1:0]   ax_reg [3], ax_next [3];
    logic signed [UW-1:0]   un_reg [3], un_next [3];
    logic signed [DW-1:0]   ay_reg [3], ay_next [3];
    logic signed [DW-1:0]   zb_reg [3], zb_next [3];
    logic signed [DW-1:0]   tr_reg [3], tr_next [3];

    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [PW-1:0]   acc_reg, acc_next;
    logic [SW-1:0]          sq_x_reg, sq_x_next;
    logic [SW-1:0]          sq_r_reg, sq_r_next;
    logic [SW-1:0]          sq_bit_reg, sq_bit_next;
    logic [DW:0]            rem_reg, rem_next;
    logic [FRAC_BITS:0]     qt_reg, qt_next;
    logic [DC_W-1:0]        dcnt_reg, dcnt_next;

    logic signed [MW-1:0]   va [3];
    logic signed [MW-1:0]   vb [3];
    logic [1:0]             ia, ib, jx, kx, ti_last;
    logic                   op_neg;
    logic signed [PW-1:0]   mul_out;
    logic signed [PW-1:0]   acc_adj;
    logic signed [PW-1:0]   acc_q;
    logic [NV_W-1:0]        mx;
    logic [SW-1:0]          sq_try;
    logic [DW:0]            len_ext;
    logic [DW:0]            rem_sub;
    logic                   dbit;
    logic [FRAC_BITS:0]     qt_fin;
    logic [FRAC_BITS:0]     qt_cap;
    logic signed [UW-1:0]   nval;
    logic                   is_norm;

    assign is_norm = (pc_reg == lavm_pkg::PG_AZ) || (pc_reg == lavm_pkg::PG_AX)
                  || (pc_reg == lavm_pkg::PG_UN);

    always_comb begin
        jx      = lavm_pkg::nxt3(ci_reg);
        kx      = lavm_pkg::nxt3(jx);
        ia      = ti_reg;
        ib      = ti_reg;
        op_neg  = 1'b0;
        ti_last = 2'd2;
        for (int i = 0; i < 3; i++) begin
            va[i] = $signed({2'b00, m_reg[i][30:0]});
            vb[i] = $signed({2'b00, m_reg[i][30:0]});
        end
        case (pc_reg)
            lavm_pkg::PG_UX: begin
                va[0] = MW'(up_x);
                va[1] = MW'(up_y);
                va[2] = MW'(up_z);
                for (int i = 0; i < 3; i++) vb[i] = MW'(az_reg[i]);
            end
            lavm_pkg::PG_AY: begin
                for (int i = 0; i < 3; i++) begin
                    va[i] = MW'(az_reg[i]);
                    vb[i] = MW'(ax_reg[i]);
                end
            end
            lavm_pkg::PG_ZB: begin
                for (int i = 0; i < 3; i++) begin
                    va[i] = MW'(ax_reg[i]);
                    vb[i] = MW'(un_reg[i]);
                end
            end
            lavm_pkg::PG_T: begin
                for (int i = 0; i < 3; i++) begin
                    va[i] = (ci_reg == 2'd0) ? MW'(ax_reg[i])
                          : (ci_reg == 2'd1) ? MW'(ay_reg[i]) : MW'(az_reg[i]);
                    vb[i] = MW'(eye_reg[i]);
                end
            end
            default: ;
        endcase
        if (pc_reg == lavm_pkg::PG_UX || pc_reg == lavm_pkg::PG_AY
                || pc_reg == lavm_pkg::PG_ZB) begin
            ti_last = 2'd1;
            if (ti_reg == 2'd0) begin
                ia = jx;
                ib = kx;
            end else begin
                ia     = kx;
                ib     = jx;
                op_neg = 1'b1;
            end
        end
    end

    assign mul_out = va[ia] * vb[ib];
    assign acc_adj = acc_reg + (acc_reg[PW-1] ? ONE_M1 : '0);
    assign acc_q   = acc_adj >>> FRAC_BITS;

    always_comb begin
        mx = m_reg[0];
        if (m_reg[1] > mx) mx = m_reg[1];
        if (m_reg[2] > mx) mx = m_reg[2];
    end

    assign sq_try  = sq_r_reg + sq_bit_reg;
    assign len_ext = {1'b0, sq_r_reg[DW-1:0]};
    assign dbit    = rem_reg >= len_ext;
    assign rem_sub = dbit ? rem_reg - len_ext : rem_reg;
    assign qt_fin  = {qt_reg[FRAC_BITS-1:0], dbit};
    assign qt_cap  = (qt_fin > ONE_Q) ? ONE_Q : qt_fin;
    assign nval    = nv_reg[ci_reg][NV_W-1] ? -$signed(UW'(qt_cap)) : $signed(UW'(qt_cap));

    always_comb begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        ci_next     = ci_reg;
        ti_next     = ti_reg;
        degen_next  = degen_reg;
        eye_next    = eye_reg;
        nv_next     = nv_reg;
        m_next      = m_reg;
        az_next     = az_reg;
        ax_next     = ax_reg;
        un_next     = un_reg;
        ay_next     = ay_reg;
        zb_next     = zb_reg;
        tr_next     = tr_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        sq_x_next   = sq_x_reg;
        sq_r_next   = sq_r_reg;
        sq_bit_next = sq_bit_reg;
        rem_next    = rem_reg;
        qt_next     = qt_reg;
        dcnt_next   = dcnt_reg;
        q_ready     = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            lavm_pkg::ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    eye_next[0] = q_item.eye_x;
                    eye_next[1] = q_item.eye_y;
                    eye_next[2] = q_item.eye_z;
                    nv_next[0]  = NV_W'(q_item.d_x);
                    nv_next[1]  = NV_W'(q_item.d_y);
                    nv_next[2]  = NV_W'(q_item.d_z);
                    degen_next  = q_item.degen;
                    pc_next     = lavm_pkg::PG_AZ;
                    state_next  = lavm_pkg::ST_NMAG;
                end
            end
            lavm_pkg::ST_NMAG: begin
                for (int i = 0; i < 3; i++) begin
                    m_next[i] = nv_reg[i][NV_W-1] ? NV_W'(-nv_reg[i]) : NV_W'(nv_reg[i]);
                end
                if (nv_reg[0] == '0 && nv_reg[1] == '0 && nv_reg[2] == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        case (pc_reg)
                            lavm_pkg::PG_AZ: az_next[i] = '0;
                            lavm_pkg::PG_AX: ax_next[i] = '0;
                            default:         un_next[i] = '0;
                        endcase
                    end
                    state_next = lavm_pkg::ST_NEXT;
                end else begin
                    state_next = lavm_pkg::ST_NSHIFT;
                end
            end
            lavm_pkg::ST_NSHIFT: begin
                if (mx >= TH_HI4) begin
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] >> 4;
                end else if (mx >= TH_HI) begin
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] >> 1;
                end else if (mx < TH_LO4) begin
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] << 4;
                end else if (mx < TH_LO) begin
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] << 1;
                end else begin
                    ti_next    = 2'd0;
                    acc_next   = '0;
                    state_next = lavm_pkg::ST_MUL;
                end
            end
            lavm_pkg::ST_MUL: begin
                prod_next  = mul_out;
                state_next = lavm_pkg::ST_ACC;
            end
            lavm_pkg::ST_ACC: begin
                acc_next = op_neg ? acc_reg - prod_reg : acc_reg + prod_reg;
                if (ti_reg == ti_last) begin
                    state_next = lavm_pkg::ST_POST;
                end else begin
                    ti_next    = ti_reg + 2'd1;
                    state_next = lavm_pkg::ST_MUL;
                end
            end
            lavm_pkg::ST_POST: begin
                if (is_norm) begin
                    sq_x_next   = acc_reg[SW-1:0];
                    sq_r_next   = '0;
                    sq_bit_next = BIT_INIT;
                    state_next  = lavm_pkg::ST_SQRT;
                end else begin
                    case (pc_reg)
                        lavm_pkg::PG_UX: nv_next[ci_reg] = acc_reg[NV_W-1:0];
                        lavm_pkg::PG_AY: ay_next[ci_reg] = lavm_pkg::sat32(acc_q);
                        lavm_pkg::PG_ZB: zb_next[ci_reg] = lavm_pkg::sat32(acc_q);
                        default:         tr_next[ci_reg] = lavm_pkg::sat32(-acc_q);
                    endcase
                    if (ci_reg == 2'd2) begin
                        state_next = lavm_pkg::ST_NEXT;
                    end else begin
                        ci_next    = ci_reg + 2'd1;
                        ti_next    = 2'd0;
                        acc_next   = '0;
                        state_next = lavm_pkg::ST_MUL;
                    end
                end
            end
            lavm_pkg::ST_SQRT: begin
                if (sq_x_reg >= sq_try) begin
                    sq_x_next = sq_x_reg - sq_try;
                    sq_r_next = (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_next = sq_r_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_next == '0) begin
                    ci_next    = 2'd0;
                    state_next = lavm_pkg::ST_DINIT;
                end
            end
            lavm_pkg::ST_DINIT: begin
                rem_next   = (DW + 1)'(m_reg[ci_reg][30:0]);
                qt_next    = '0;
                dcnt_next  = DC_W'(FRAC_BITS);
                state_next = lavm_pkg::ST_DIV;
            end
            lavm_pkg::ST_DIV: begin
                qt_next  = qt_fin;
                rem_next = rem_sub << 1;
                if (dcnt_reg == '0) begin
                    case (pc_reg)
                        lavm_pkg::PG_AZ: az_next[ci_reg] = nval;
                        lavm_pkg::PG_AX: ax_next[ci_reg] = nval;
                        default:         un_next[ci_reg] = nval;
                    endcase
                    if (ci_reg == 2'd2) begin
                        state_next = lavm_pkg::ST_NEXT;
                    end else begin
                        ci_next    = ci_reg + 2'd1;
                        state_next = lavm_pkg::ST_DINIT;
                    end
                end else begin
                    dcnt_next = dcnt_reg - 1'b1;
                end
            end
            lavm_pkg::ST_NEXT: begin
                ci_next  = 2'd0;
                ti_next  = 2'd0;
                acc_next = '0;
                case (pc_reg)
                    lavm_pkg::PG_AZ: begin
                        pc_next    = lavm_pkg::PG_UX;
                        state_next = lavm_pkg::ST_MUL;
                    end
                    lavm_pkg::PG_UX: begin
                        pc_next    = lavm_pkg::PG_AX;
                        state_next = lavm_pkg::ST_NMAG;
                    end
                    lavm_pkg::PG_AX: begin
                        pc_next    = lavm_pkg::PG_AY;
                        state_next = lavm_pkg::ST_MUL;
                    end
                    lavm_pkg::PG_AY: begin
                        pc_next    = lavm_pkg::PG_T;
                        state_next = lavm_pkg::ST_MUL;
                    end
                    lavm_pkg::PG_T: begin
                        pc_next    = lavm_pkg::PG_UN;
                        nv_next[0] = NV_W'(up_x);
                        nv_next[1] = NV_W'(up_y);
                        nv_next[2] = NV_W'(up_z);
                        state_next = lavm_pkg::ST_NMAG;
                    end
                    lavm_pkg::PG_UN: begin
                        pc_next    = lavm_pkg::PG_ZB;
                        state_next = lavm_pkg::ST_MUL;
                    end
                    default: begin
                        state_next = lavm_pkg::ST_HAND;
                    end
                endcase
            end
            lavm_pkg::ST_HAND: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = lavm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lavm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            res.ax[i] = DW'(ax_reg[i]);
            res.ay[i] = ay_reg[i];
            res.az[i] = DW'(az_reg[i]);
            res.tr[i] = tr_reg[i];
            res.un[i] = DW'(un_reg[i]);
            res.zb[i] = zb_reg[i];
        end
        res.degen = degen_reg;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= lavm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk) begin
        pc_reg     <= pc_next;
        ci_reg     <= ci_next;
        ti_reg     <= ti_next;
        degen_reg  <= degen_next;
        eye_reg    <= eye_next;
        nv_reg     <= nv_next;
        m_reg      <= m_next;
        az_reg     <= az_next;
        ax_reg     <= ax_next;
        un_reg     <= un_next;
        ay_reg     <= ay_next;
        zb_reg     <= zb_next;
        tr_reg     <= tr_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        sq_x_reg   <= sq_x_next;
        sq_r_reg   <= sq_r_next;
        sq_bit_reg <= sq_bit_next;
        rem_reg    <= rem_next;
        qt_reg     <= qt_next;
        dcnt_reg   <= dcnt_next;
    end

endmodule

// ===== hdl/lavm_emit.sv =====
module lavm_emit #(
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rstn,
    input  logic                        res_valid,
    output logic                        res_ready,
    input  lavm_pkg::res_t              res,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_matrix_id,
    output logic [1:0]                  m_row_index,
    output logic signed [31:0]          m_col0,
    output logic signed [31:0]          m_col1,
    output logic signed [31:0]          m_col2,
    output logic signed [31:0]          m_col3,
    output logic                        m_degenerate,
    output logic                        m_last_row
);

    localparam int DW = lavm_pkg::DATA_W;
    localparam logic [DW-1:0] ONE_D = DW'(1) << FRAC_BITS;

    lavm_pkg::res_t                 buf_reg;
    logic                           buf_valid_reg;
    logic [lavm_pkg::ROW_W-1:0]     row_reg;
    logic                           m_valid_reg;
    logic [1:0]                     mid, ri;
    logic [DW-1:0]                  c0, c1, c2, c3;
    logic                           load_out;
    logic                           last;

    assign res_ready = !buf_valid_reg;
    assign load_out  = buf_valid_reg && (!m_valid_reg || m_ready);
    assign mid       = row_reg[3:2];
    assign ri        = row_reg[1:0];
    assign last      = row_reg == lavm_pkg::ROW_W'(lavm_pkg::ROWS - 1);
    assign m_valid   = m_valid_reg;

    always_comb begin
        c0 = '0;
        c1 = '0;
        c2 = '0;
        c3 = '0;
        if (ri == lavm_pkg::ROW_LAST) begin
            if (mid == lavm_pkg::MAT_VIEW) begin
                c0 = buf_reg.tr[0];
                c1 = buf_reg.tr[1];
                c2 = buf_reg.tr[2];
            end
            c3 = ONE_D;
        end else begin
            case (mid)
                lavm_pkg::MAT_VIEW: begin
                    c0 = buf_reg.ax[ri];
                    c1 = buf_reg.ay[ri];
                    c2 = buf_reg.az[ri];
                end
                lavm_pkg::MAT_BILL: begin
                    c0 = (ri == 2'd0) ? buf_reg.ax[0] : (ri == 2'd1) ? buf_reg.ay[0] : buf_reg.az[0];
                    c1 = (ri == 2'd0) ? buf_reg.ax[1] : (ri == 2'd1) ? buf_reg.ay[1] : buf_reg.az[1];
                    c2 = (ri == 2'd0) ? buf_reg.ax[2] : (ri == 2'd1) ? buf_reg.ay[2] : buf_reg.az[2];
                end
                default: begin
                    c0 = (ri == 2'd0) ? buf_reg.ax[0] : (ri == 2'd1) ? buf_reg.un[0] : buf_reg.zb[0];
                    c1 = (ri == 2'd0) ? buf_reg.ax[1] : (ri == 2'd1) ? buf_reg.un[1] : buf_reg.zb[1];
                    c2 = (ri == 2'd0) ? buf_reg.ax[2] : (ri == 2'd1) ? buf_reg.un[2] : buf_reg.zb[2];
                end
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (res_valid && res_ready) begin
            buf_reg <= res;
        end
        if (load_out) begin
            m_matrix_id  <= mid;
            m_row_index  <= ri;
            m_col0       <= c0;
            m_col1       <= c1;
            m_col2       <= c2;
            m_col3       <= c3;
            m_degenerate <= buf_reg.degen;
            m_last_row   <= last;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            buf_valid_reg <= 1'b0;
            row_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                buf_valid_reg <= 1'b1;
                row_reg       <= '0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
                if (last) begin
                    buf_valid_reg <= 1'b0;
                    row_reg       <= '0;
                end else begin
                    row_reg <= row_reg + 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam longint ONE_Q = 64'sd65536;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 600;

    typedef longint vec3_t [3];

    typedef struct {
        logic [31:0] eye [3];
        logic [31:0] tgt [3];
    } pose_t;

    typedef struct {
        logic [1:0]  mid;
        logic [1:0]  row;
        logic [31:0] col [4];
        logic        degen;
        logic        last;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [31:0] s_eye_x = '0, s_eye_y = '0, s_eye_z = '0;
    logic signed [31:0] s_target_x = '0, s_target_y = '0, s_target_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_matrix_id, m_row_index;
    logic signed [31:0] m_col0, m_col1, m_col2, m_col3;
    logic        m_degenerate, m_last_row;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    look_at_view_matrix_core uut (.*);

    pose_t  pending [$];
    row_t   rows_due [$];
    longint up_vec [3] = '{0, ONE_Q, 0};
    int     tx_idle = 0, rx_idle = 0;
    bit     hold_off = 1'b0;
    logic   in_taken = 1'b0;
    int     err_count = 0;
    int     rows_seen = 0, poses_sent = 0;
    longint cycles = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic longint clamp_q(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic vec3_t unit_vec(vec3_t v);
        longint unsigned m [3];
        longint unsigned mx, sum, len, c;
        int dn, upc;
        vec3_t o;
        mx = 0; sum = 0; dn = 0; upc = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            o = '{0, 0, 0};
            return o;
        end
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            dn++;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            upc++;
        end
        for (int i = 0; i < 3; i++) begin
            m[i] = (m[i] >> dn) << upc;
            sum += m[i] * m[i];
        end
        len = sqrt_floor(sum);
        for (int i = 0; i < 3; i++) begin
            c = (m[i] << 16) / len;
            if (c > 64'd65536) c = 64'd65536;
            o[i] = (v[i] < 0) ? -longint'(c) : longint'(c);
        end
        return o;
    endfunction

    function automatic vec3_t cross_q(vec3_t a, vec3_t b);
        vec3_t o;
        o[0] = clamp_q((a[1] * b[2] - a[2] * b[1]) / ONE_Q);
        o[1] = clamp_q((a[2] * b[0] - a[0] * b[2]) / ONE_Q);
        o[2] = clamp_q((a[0] * b[1] - a[1] * b[0]) / ONE_Q);
        return o;
    endfunction

    task automatic add_row(int k, int mid, int row, longint c0, longint c1, longint c2,
                           longint c3, bit dg);
        row_t r;
        r.mid = mid[1:0];
        r.row = row[1:0];
        r.col[0] = 32'(clamp_q(c0));
        r.col[1] = 32'(clamp_q(c1));
        r.col[2] = 32'(clamp_q(c2));
        r.col[3] = 32'(clamp_q(c3));
        r.degen = dg;
        r.last = (k == 11);
        rows_due.push_back(r);
    endtask

    task automatic predict_camera(pose_t p);
        vec3_t eye, dir, uv, ux, ax, ay, az, un, zb;
        longint tr [3];
        bit dg;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'(signed'(p.eye[i]));
            dir[i] = longint'(signed'(p.tgt[i])) - eye[i];
            uv[i] = up_vec[i];
        end
        dg = (dir[0] == 0 && dir[1] == 0 && dir[2] == 0) ||
             (uv[0] == 0 && uv[1] == 0 && uv[2] == 0);
        az = unit_vec(dir);
        ux[0] = uv[1] * az[2] - uv[2] * az[1];
        ux[1] = uv[2] * az[0] - uv[0] * az[2];
        ux[2] = uv[0] * az[1] - uv[1] * az[0];
        ax = unit_vec(ux);
        ay = cross_q(az, ax);
        tr[0] = -((ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]) / ONE_Q);
        tr[1] = -((ay[0] * eye[0] + ay[1] * eye[1] + ay[2] * eye[2]) / ONE_Q);
        tr[2] = -((az[0] * eye[0] + az[1] * eye[1] + az[2] * eye[2]) / ONE_Q);
        un = unit_vec(uv);
        zb = cross_q(ax, un);
        for (int i = 0; i < 3; i++)
            add_row(i, lavm_pkg::MAT_VIEW, i, ax[i], ay[i], az[i], 0, dg);
        add_row(3, lavm_pkg::MAT_VIEW, 3, tr[0], tr[1], tr[2], ONE_Q, dg);
        add_row(4, lavm_pkg::MAT_BILL, 0, ax[0], ax[1], ax[2], 0, dg);
        add_row(5, lavm_pkg::MAT_BILL, 1, ay[0], ay[1], ay[2], 0, dg);
        add_row(6, lavm_pkg::MAT_BILL, 2, az[0], az[1], az[2], 0, dg);
        add_row(7, lavm_pkg::MAT_BILL, 3, 0, 0, 0, ONE_Q, dg);
        add_row(8, lavm_pkg::MAT_YBILL, 0, ax[0], ax[1], ax[2], 0, dg);
        add_row(9, lavm_pkg::MAT_YBILL, 1, un[0], un[1], un[2], 0, dg);
        add_row(10, lavm_pkg::MAT_YBILL, 2, zb[0], zb[1], zb[2], 0, dg);
        add_row(11, lavm_pkg::MAT_YBILL, 3, 0, 0, 0, ONE_Q, dg);
    endtask

    // driver
    always @(negedge aclk) begin : drive_poses
        pose_t p;
        if (aresetn) begin
            if (s_valid && !in_taken) begin
            end else if (pending.size() > 0 && !hold_off &&
                         $urandom_range(99) >= tx_idle) begin
                p = pending.pop_front();
                s_eye_x <= p.eye[0];
                s_eye_y <= p.eye[1];
                s_eye_z <= p.eye[2];
                s_target_x <= p.tgt[0];
                s_target_y <= p.tgt[1];
                s_target_z <= p.tgt[2];
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // monitor
    always @(posedge aclk) begin : watch_rows
        pose_t p;
        row_t r;
        logic [31:0] got [4];
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        in_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            p.eye = '{s_eye_x, s_eye_y, s_eye_z};
            p.tgt = '{s_target_x, s_target_y, s_target_z};
            predict_camera(p);
            poses_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            rows_seen++;
            if (rows_due.size() == 0) begin
                $error("unexpected row transaction matrix_id %0d row_index %0d",
                       m_matrix_id, m_row_index);
                err_count++;
            end else begin
                r = rows_due.pop_front();
                got = '{m_col0, m_col1, m_col2, m_col3};
                if (m_matrix_id !== r.mid) begin
                    $error("matrix_id expected %0d got %0d", r.mid, m_matrix_id);
                    err_count++;
                end
                if (m_row_index !== r.row) begin
                    $error("row_index expected %0d got %0d", r.row, m_row_index);
                    err_count++;
                end
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== r.col[i]) begin
                        $error("col%0d expected %0d got %0d", i, signed'(r.col[i]),
                               signed'(got[i]));
                        err_count++;
                    end
                end
                if (m_degenerate !== r.degen) begin
                    $error("degenerate expected %0d got %0d", r.degen, m_degenerate);
                    err_count++;
                end
                if (m_last_row !== r.last) begin
                    $error("last_row expected %0d got %0d", r.last, m_last_row);
                    err_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending.size() > 0 || s_valid || rows_due.size() > 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        up_vec[idx] = longint'(signed'(val));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_up(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        wait_drained();
        write_reg(lavm_pkg::CFG_UP_X, x);
        write_reg(lavm_pkg::CFG_UP_Y, y);
        write_reg(lavm_pkg::CFG_UP_Z, z);
    endtask

    task automatic add_pose(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                            logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
        pose_t p;
        p.eye = '{ex, ey, ez};
        p.tgt = '{tx, ty, tz};
        pending.push_back(p);
    endtask

    function automatic logic [31:0] rand_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return {{12{1'($urandom_range(1))}}, 20'($urandom)};
        if (sel < 8) return $urandom;
        return {{14{1'($urandom_range(1))}}, 2'($urandom_range(3)), 16'd0};
    endfunction

    task automatic add_random(int n);
        logic [31:0] e [3];
        logic [31:0] t [3];
        int sel;
        repeat (n) begin
            for (int i = 0; i < 3; i++) begin
                e[i] = rand_coord();
                t[i] = rand_coord();
            end
            sel = $urandom_range(9);
            if (sel == 0) begin
                t = e;
            end else if (sel == 1) begin
                for (int i = 0; i < 3; i++)
                    t[i] = e[i] + (32'(up_vec[i]) >>> $urandom_range(8));
            end else if (sel == 2) begin
                t = e;
                t[$urandom_range(2)] += $urandom_range(1) ? 32'd1 : 32'hffff_ffff;
            end
            add_pose(e[0], e[1], e[2], t[0], t[1], t[2]);
        end
    endtask

    localparam logic [31:0] QMAX = 32'h7fff_ffff;
    localparam logic [31:0] QMIN = 32'h8000_0000;
    localparam logic [31:0] Q1 = 32'h0001_0000;
    localparam logic [31:0] QN1 = 32'hffff_0000;

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle = 20;
        rx_idle = 61;
        set_up(32'd0, Q1, 32'd0);
        add_pose(0, 0, 0, 0, 0, Q1);
        add_pose(0, 0, 0, 0, 0, 0);
        add_pose(Q1, Q1, Q1, Q1, Q1, Q1);
        add_pose(0, 0, 0, 0, Q1, 0);
        add_pose(0, 0, 0, 0, QN1, 0);
        add_pose(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX);
        add_pose(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN);
        add_pose(QMAX, QMIN, QMAX, QMAX, QMAX, QMIN);
        add_pose(QMIN, 0, QMAX, QMIN, 0, QMAX - 1);
        add_pose(0, 0, 0, 32'd1, 0, 0);
        add_pose(0, 0, 0, 0, 0, 32'hffff_ffff);
        add_pose(QMAX, QMAX, QMAX, 0, 0, 0);
        add_pose(QN1, Q1, QN1, Q1, QN1, Q1);
        add_pose(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
        add_pose(32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f, 0, 0, 0);
        wait (pending.size() <= 8);
        hold_off = 1'b1;
        while (s_valid || rows_due.size() > 0)
            @(posedge aclk);
        hold_off = 1'b0;
        add_random(30);

        set_up(QMIN, QMAX, QMIN);
        add_pose(0, 0, 0, 0, 0, Q1);
        add_pose(0, 0, 0, QN1, Q1, QN1);
        add_random(40);

        tx_idle = 61;
        rx_idle = 20;
        set_up(32'd0, 32'd0, 32'd0);
        add_pose(0, 0, 0, 0, 0, Q1);
        add_pose(QMIN, QMAX, 0, QMAX, QMIN, 0);
        add_random(35);

        set_up($urandom, $urandom, $urandom);
        add_random(45);

        tx_idle = 0;
        rx_idle = 0;
        set_up(QMAX, 32'd0, 32'd1);
        add_pose(0, 0, 0, Q1, 0, 0);
        add_random(45);

        set_up(32'hffff_ffff, QN1, 32'h0000_8000);
        add_random(45);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d camera poses and %0d matrix rows across six up-vector settings,",
                 poses_sent, rows_seen);
        $display("including zero, extreme and random up vectors with and without back-pressure.");
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
